### rtl/core/ordered_list_table_engine_macros.svh
// assertion macros used by the checker file
`ifndef ORDERED_LIST_TABLE_ENGINE_MACROS_SVH
`define ORDERED_LIST_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define OLTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OLTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/olte_pkg.sv
// shared types and constants of the ordered list table engine
`default_nettype none

package olte_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_GET        = 3'd0,
    CMD_SET        = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_FIND_FIRST = 3'd4,
    CMD_FIND_LAST  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FAILED    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PLACE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### rtl/core/olte_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module olte_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/ordered_list_table_engine.sv
// ordered list table engine: fixed-capacity ordered word list with count
//
// a command (cmd_i, position_i, value_in_i) is taken at a clock edge with
// start high and busy low. busy stays high until the result has been shown.
// each command gives one result: status_o, value_out_o, found_at_o and fill_o
// are valid for exactly one cycle while valid_o is high; the receiver cannot
// hold them off and must take them in that cycle.
// set in range, a rejected or unknown command and a find on an empty list go
// straight to the result. get, remove and find walk the entries through the ram;
// insert walks down from the top entry to move each entry up, then places the
// word; an append by set or insert places the word with no walk. a find stops at
// its first hit. a new command is accepted from the cycle after the strobe. the
// entries sit in a ram with one read and one write port; each moved or examined
// entry is read through the read port, and each moved entry is written back
// through the write port.
// reset clears the count and the sequencer; the ram contents are not cleared,
// and only entries below the count are ever read.
`default_nettype none

module ordered_list_table_engine
  import olte_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [4:0]  position_i,
  input  wire logic [31:0] value_in_i,
  output logic             valid_o,
  output logic [1:0]       status_o,
  output logic [31:0]      value_out_o,
  output logic [3:0]       found_at_o,
  output logic [4:0]       fill_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CW > 5) ? CW : 5;

  state_e state_q, state_d;

  logic [CW-1:0]    used_q, used_d;
  logic             rd_active_q, rd_active_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]    rd_end_q, rd_end_d;
  cmd_e             cmd_q, cmd_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [WIDTH-1:0] word_q, word_d;
  status_e          status_q, status_d;
  logic [WIDTH-1:0] vout_q, vout_d;
  logic [AW-1:0]    at_q, at_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [WIDTH-1:0] ram_wdata, ram_rdata;

  logic [CmpW-1:0]  pos_ext, used_ext;
  logic             in_range, at_end, full, nonempty;
  logic             is_find, hit, last;
  logic             walk_down;

  assign pos_ext  = CmpW'(position_i);
  assign used_ext = CmpW'(used_q);
  assign in_range = pos_ext < used_ext;
  assign at_end   = pos_ext == used_ext;
  assign full     = used_q == CW'(DEPTH);
  assign nonempty = used_q != '0;

  assign is_find   = (cmd_q == CMD_FIND_FIRST) || (cmd_q == CMD_FIND_LAST);
  assign hit       = pend_q && is_find && (ram_rdata == word_q);
  assign last      = pend_q && !rd_active_q;
  assign walk_down = (cmd_q == CMD_INSERT) || (cmd_q == CMD_FIND_LAST);

  olte_ram #(
    .Width (WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_e'(cmd_i))
            CMD_GET:    state_d = in_range ? ST_RUN : ST_DONE;
            CMD_SET:    state_d = (!in_range && at_end && !full) ? ST_PLACE : ST_DONE;
            CMD_INSERT: begin
              if (full) begin
                state_d = ST_DONE;
              end else if (in_range) begin
                state_d = ST_RUN;
              end else if (at_end) begin
                state_d = ST_PLACE;
              end else begin
                state_d = ST_DONE;
              end
            end
            CMD_REMOVE:     state_d = in_range ? ST_RUN : ST_DONE;
            CMD_FIND_FIRST: state_d = nonempty ? ST_RUN : ST_DONE;
            CMD_FIND_LAST:  state_d = nonempty ? ST_RUN : ST_DONE;
            default:        state_d = ST_DONE;
          endcase
        end
      end
      ST_RUN: begin
        if (hit) begin
          state_d = ST_DONE;
        end else if (last) begin
          state_d = (cmd_q == CMD_INSERT) ? ST_PLACE : ST_DONE;
        end
      end
      ST_PLACE: state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    used_d      = used_q;
    rd_active_d = 1'b0;
    pend_d      = 1'b0;
    pend_addr_d = rd_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    rd_end_d    = rd_end_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    word_d      = word_q;
    status_d    = status_q;
    vout_d      = vout_q;
    at_d        = at_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = word_q;
    ram_re      = 1'b0;
    ram_raddr   = rd_ptr_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d    = cmd_e'(cmd_i);
          pos_d    = pos_ext[AW-1:0];
          word_d   = WIDTH'(value_in_i);
          status_d = STATUS_FAILED;
          vout_d   = '0;
          at_d     = '0;
          case (cmd_e'(cmd_i))
            CMD_GET: begin
              if (in_range) begin
                status_d    = STATUS_OK;
                rd_ptr_d    = pos_ext[AW-1:0];
                rd_end_d    = pos_ext[AW-1:0];
                rd_active_d = 1'b1;
              end else begin
                status_d = STATUS_NOT_FOUND;
              end
            end
            CMD_SET: begin
              if (in_range) begin
                // overwrite in place, no walk needed
                status_d  = STATUS_OK;
                ram_we    = 1'b1;
                ram_waddr = pos_ext[AW-1:0];
                ram_wdata = WIDTH'(value_in_i);
              end else if (at_end && !full) begin
                status_d = STATUS_OK;
              end
            end
            CMD_INSERT: begin
              if (!full && (in_range || at_end)) begin
                status_d    = STATUS_OK;
                // walk from the top entry down to the insert point
                rd_ptr_d    = AW'(used_q - 1'b1);
                rd_end_d    = pos_ext[AW-1:0];
                rd_active_d = in_range;
              end
            end
            CMD_REMOVE: begin
              if (in_range) begin
                status_d    = STATUS_OK;
                rd_ptr_d    = pos_ext[AW-1:0];
                rd_end_d    = AW'(used_q - 1'b1);
                rd_active_d = 1'b1;
              end
            end
            CMD_FIND_FIRST: begin
              status_d    = STATUS_NOT_FOUND;
              rd_ptr_d    = '0;
              rd_end_d    = AW'(used_q - 1'b1);
              rd_active_d = nonempty;
            end
            CMD_FIND_LAST: begin
              status_d    = STATUS_NOT_FOUND;
              rd_ptr_d    = AW'(used_q - 1'b1);
              rd_end_d    = '0;
              rd_active_d = nonempty;
            end
            default: begin
              status_d = STATUS_FAILED;
            end
          endcase
        end
      end

      ST_RUN: begin
        // issue one read a cycle, handle the data of last cycle's read
        if (rd_active_q) begin
          ram_re      = 1'b1;
          ram_raddr   = rd_ptr_q;
          pend_d      = 1'b1;
          pend_addr_d = rd_ptr_q;
          if (rd_ptr_q != rd_end_q) begin
            rd_active_d = 1'b1;
            rd_ptr_d    = walk_down ? AW'(rd_ptr_q - 1'b1) : AW'(rd_ptr_q + 1'b1);
          end
        end
        if (pend_q) begin
          case (cmd_q)
            CMD_GET: begin
              vout_d = ram_rdata;
            end
            CMD_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(pend_addr_q + 1'b1);
              ram_wdata = ram_rdata;
            end
            CMD_REMOVE: begin
              if (pend_addr_q == pos_q) begin
                vout_d = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(pend_addr_q - 1'b1);
                ram_wdata = ram_rdata;
              end
            end
            CMD_FIND_FIRST, CMD_FIND_LAST: begin
              if (ram_rdata == word_q) begin
                status_d = STATUS_OK;
                at_d     = pend_addr_q;
              end
            end
            default: begin
            end
          endcase
        end
        if (hit) begin
          rd_active_d = 1'b0;
          pend_d      = 1'b0;
        end else if (last && (cmd_q == CMD_REMOVE)) begin
          used_d = CW'(used_q - 1'b1);
        end
      end

      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = word_q;
        used_d    = CW'(used_q + 1'b1);
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      rd_active_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rd_active_q <= rd_active_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    rd_ptr_q    <= rd_ptr_d;
    rd_end_q    <= rd_end_d;
    cmd_q       <= cmd_d;
    pos_q       <= pos_d;
    word_q      <= word_d;
    status_q    <= status_d;
    vout_q      <= vout_d;
    at_q        <= at_d;
  end

  assign busy        = state_q != ST_IDLE;
  assign valid_o     = state_q == ST_DONE;
  assign status_o    = status_q;
  assign value_out_o = 32'(vout_q);
  assign found_at_o  = 4'(at_q);
  assign fill_o      = 5'(used_q);

endmodule

`default_nettype wire

### rtl/core/olte_checker.sv
// port-level checker for the ordered list table engine, bound to the top level
`default_nettype none
`include "ordered_list_table_engine_macros.svh"

module olte_checker
  import olte_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        valid_o,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] value_out_o
);

  // a result is only shown while the command still holds the block
  `OLTE_ASSERT_NOW(a_result_while_busy, valid_o, busy, "result strobe while not busy")

  // an accepted transaction occupies the block in the next cycle
  `OLTE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "block not busy after accept")

  // the strobe lasts one cycle
  `OLTE_ASSERT_NEXT(a_strobe_single, valid_o, !valid_o, "result strobe longer than a cycle")

  // busy drops only once the result has gone out
  `OLTE_ASSERT_NOW(a_release_after_result, $fell(busy), $past(valid_o),
                   "busy released without a result")

  // no data word leaves with a failed or empty lookup
  `OLTE_ASSERT_NOW(a_value_zero_unless_ok, valid_o && (status_o != STATUS_OK),
                   value_out_o == 32'd0, "data word on an unsuccessful result")

endmodule

bind ordered_list_table_engine olte_checker u_olte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .status_o    (status_o),
  .value_out_o (value_out_o)
);

`default_nettype wire

### verif/tb_top.sv
// self-checking testbench of the ordered list table engine
`timescale 1ns / 1ps

module tb_top;
  import olte_pkg::*;

  // codes the block must reject as unknown commands
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } mode_e;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [3:0]  found_at;
    logic [4:0]  fill;
  } list_result_t;

  // shadow copy of the list plus the queue of outstanding responses
  class list_checker;
    logic [31:0]  shadow_words [DEPTH_DEF];
    int           shadow_count;
    list_result_t pending_results [$];
    int           mismatches;

    function new();
      shadow_count = 0;
      mismatches = 0;
    endfunction

    function void place_word(int pos, logic [31:0] word);
      int i;
      for (i = shadow_count; i > pos; i--) begin
        shadow_words[i] = shadow_words[i-1];
      end
      shadow_words[pos] = word;
      shadow_count++;
    endfunction

    function void note_command(logic [2:0] op, logic [4:0] pos, logic [31:0] word);
      list_result_t r;
      int i;
      r.status = STATUS_FAILED;
      r.value = '0;
      r.found_at = '0;
      case (op)
        CMD_GET: begin
          if (pos < shadow_count) begin
            r.value = shadow_words[pos[3:0]];
            r.status = STATUS_OK;
          end else begin
            r.status = STATUS_NOT_FOUND;
          end
        end
        CMD_SET: begin
          if (pos < shadow_count) begin
            shadow_words[pos[3:0]] = word;
            r.status = STATUS_OK;
          end else if (pos == shadow_count && shadow_count < DEPTH_DEF) begin
            place_word(pos, word);
            r.status = STATUS_OK;
          end
        end
        CMD_INSERT: begin
          if (pos <= shadow_count && shadow_count < DEPTH_DEF) begin
            place_word(pos, word);
            r.status = STATUS_OK;
          end
        end
        CMD_REMOVE: begin
          if (pos < shadow_count) begin
            r.value = shadow_words[pos[3:0]];
            for (i = pos + 1; i < shadow_count; i++) begin
              shadow_words[i-1] = shadow_words[i];
            end
            shadow_count--;
            r.status = STATUS_OK;
          end
        end
        CMD_FIND_FIRST: begin
          r.status = STATUS_NOT_FOUND;
          for (i = 0; i < shadow_count; i++) begin
            if (shadow_words[i] == word) begin
              r.found_at = i[3:0];
              r.status = STATUS_OK;
              break;
            end
          end
        end
        CMD_FIND_LAST: begin
          r.status = STATUS_NOT_FOUND;
          for (i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_words[i] == word) begin
              r.found_at = i[3:0];
              r.status = STATUS_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      r.fill = shadow_count[4:0];
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [1:0] status, logic [31:0] value,
                                 logic [3:0] found_at, logic [4:0] fill);
      list_result_t r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: response with no transaction outstanding", $realtime);
        end
        return;
      end
      r = pending_results.pop_front();
      if (status !== r.status || value !== r.value || found_at !== r.found_at ||
          fill !== r.fill) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp status %0d value %h at %0d fill %0d",
                   $realtime, r.status, r.value, r.found_at, r.fill);
          $display("%0t:          got status %0d value %h at %0d fill %0d",
                   $realtime, status, value, found_at, fill);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd_i = '0;
  logic [4:0]  position_i = '0;
  logic [31:0] value_in_i = '0;
  logic        valid_o;
  logic [1:0]  status_o;
  logic [31:0] value_out_o;
  logic [3:0]  found_at_o;
  logic [4:0]  fill_o;

  list_checker sb = new();

  always #5 clk_i = ~clk_i;

  ordered_list_table_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .value_in_i  (value_in_i),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .found_at_o  (found_at_o),
    .fill_o      (fill_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_response(status_o, value_out_o, found_at_o, fill_o);
    end
  end

  task automatic send_command(logic [2:0] op, logic [4:0] pos, logic [31:0] word);
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= op;
    position_i <= pos;
    value_in_i <= word;
    do @(posedge clk_i); while (busy);
    sb.note_command(op, pos, word);
  endtask

  // inputs are don't-care while start is low, so scramble them
  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      cmd_i <= 3'($urandom);
      position_i <= 5'($urandom);
      value_in_i <= $urandom;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random words mixed with held words and four fixed corner values so that duplicates and repeated keys turn up
  function automatic logic [31:0] pick_word(bit prefer_held);
    int r;
    r = $urandom_range(0, 99);
    if (prefer_held && sb.shadow_count > 0 && r < 60) begin
      return sb.shadow_words[$urandom_range(0, sb.shadow_count - 1)];
    end
    if (r < 80) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'ha5a5_5a5a;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 55) return CMD_INSERT;
        if (r < 70) return CMD_SET;
        if (r < 80) return CMD_GET;
        if (r < 88) return CMD_FIND_FIRST;
        if (r < 95) return CMD_FIND_LAST;
        if (r < 98) return CMD_REMOVE;
      end
      MODE_DRAIN: begin
        if (r < 50) return CMD_REMOVE;
        if (r < 60) return CMD_GET;
        if (r < 70) return CMD_FIND_FIRST;
        if (r < 80) return CMD_FIND_LAST;
        if (r < 88) return CMD_SET;
        if (r < 96) return CMD_INSERT;
      end
      default: begin
        if (r < 15) return CMD_GET;
        if (r < 30) return CMD_SET;
        if (r < 50) return CMD_INSERT;
        if (r < 70) return CMD_REMOVE;
        if (r < 83) return CMD_FIND_FIRST;
        if (r < 96) return CMD_FIND_LAST;
      end
    endcase
    return $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
  endfunction

  initial begin
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] word;
    mode_e       mode;
    bit          no_gaps;
    int          phase;
    int          n;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list, out-of-range indices, duplicates, unknown codes
    send_command(CMD_GET, 5'd0, 32'h0);
    send_command(CMD_REMOVE, 5'd0, 32'h0);
    send_command(CMD_FIND_FIRST, 5'd0, 32'h0);
    send_command(CMD_FIND_LAST, 5'd0, 32'hffff_ffff);
    send_command(CMD_SET, 5'd1, 32'h1111_1111);
    send_command(CMD_INSERT, 5'd1, 32'h2222_2222);
    send_command(CMD_SET, 5'd0, 32'hffff_ffff);
    send_command(CMD_INSERT, 5'd0, 32'h0000_0000);
    send_command(CMD_INSERT, 5'd2, 32'h1234_5678);
    send_command(CMD_INSERT, 5'd1, 32'hffff_ffff);
    send_command(CMD_FIND_FIRST, 5'd0, 32'hffff_ffff);
    send_command(CMD_FIND_LAST, 5'd0, 32'hffff_ffff);
    send_command(CMD_FIND_FIRST, 5'd0, 32'hdead_beef);
    send_command(CMD_GET, 5'd3, 32'h0);
    send_command(CMD_GET, 5'd4, 32'h0);
    send_command(CMD_GET, 5'd31, 32'hffff_ffff);
    send_command(CMD_SET, 5'd2, 32'h8000_0001);
    send_command(CMD_REMOVE, 5'd4, 32'h0);
    send_command(CMD_REMOVE, 5'd31, 32'h0);
    send_command(CMD_REMOVE, 5'd1, 32'h0);
    send_command(CMD_RSVD_6, 5'd0, 32'h0);
    send_command(CMD_RSVD_7, 5'd31, 32'hffff_ffff);
    send_command(CMD_INSERT, 5'd31, 32'h5555_aaaa);
    send_command(CMD_REMOVE, 5'd0, 32'h0);
    send_command(CMD_FIND_LAST, 5'd0, 32'h1234_5678);
    drain_responses();

    // the first phase favours filling the list, the second draining it
    for (phase = 0; phase < 20; phase++) begin
      if (phase == 0) mode = MODE_FILL;
      else if (phase == 1) mode = MODE_DRAIN;
      else mode = mode_e'($urandom_range(0, 2));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 25; n++) begin
        op = pick_op(mode);
        if ($urandom_range(0, 99) < 85) pos = 5'($urandom_range(0, sb.shadow_count));
        else pos = 5'($urandom_range(0, 31));
        word = pick_word(op == CMD_FIND_FIRST || op == CMD_FIND_LAST);
        send_command(op, pos, word);
        if (!no_gaps) hold_off(pick_gap());
      end
      if (phase == 10 || $urandom_range(0, 3) == 0) drain_responses();
    end

    drain_responses();
    repeat (DEPTH_DEF + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
